[design/pica_pkg.sv]
// Package for the PI controller with conditional-integration anti-windup.
// Holds the widths, formats, register codes and FSM states shared by all files.
// No dependencies.
`default_nettype none

package pica_pkg;

  // Signal format: signed, SIGNAL_WIDTH bits, 16 fraction bits.
  localparam int SIGNAL_WIDTH = 32;

  // Gain format: unsigned Q8.24.
  localparam int GAIN_W    = 32;
  localparam int GAIN_FRAC = 24;

  // Error is one bit wider than a signal, error plus integrator two bits wider.
  localparam int ERR_W = SIGNAL_WIDTH + 1;
  localparam int SUM_W = SIGNAL_WIDTH + 2;

  // Serial multiplier operand and floor-shifted product widths.
  localparam int MUL_X_W = SUM_W;
  localparam int MUL_W   = MUL_X_W + 1 + GAIN_W - GAIN_FRAC;
  localparam int CNT_W   = $clog2(GAIN_W + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = GAIN_W;

  typedef logic signed [SIGNAL_WIDTH-1:0] sig_t;
  typedef logic [GAIN_W-1:0]              gain_t;

  localparam sig_t SIG_MAX = {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
  localparam sig_t SIG_MIN = {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_P_GAIN = 1'b0,
    REG_KI_TS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT_START,
    ST_INT_WAIT,
    ST_P_START,
    ST_P_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[design/pica_if.sv]
// Valid/ready channel interfaces for the controller's tick and result streams.
// Depends on pica_pkg for the signal type.
`default_nettype none

interface pica_in_if;
  import pica_pkg::*;

  logic valid;
  logic ready;
  sig_t reference;
  sig_t feedback;
  sig_t upper_limit;
  sig_t lower_limit;

  modport source (output valid, output reference, output feedback,
                  output upper_limit, output lower_limit, input ready);
  modport sink   (input valid, input reference, input feedback,
                  input upper_limit, input lower_limit, output ready);
endinterface

interface pica_out_if;
  import pica_pkg::*;

  logic valid;
  logic ready;
  sig_t drive;
  logic clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink   (input valid, input drive, input clamped, output ready);
endinterface

`default_nettype wire

[design/pica_sermul.sv]
// Serial-parallel multiplier: signed operand times unsigned Q8.24 gain, one gain
// bit per cycle, product shifted right by 24 with floor rounding.
// Depends on pica_pkg.
`default_nettype none

module pica_sermul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [pica_pkg::MUL_X_W-1:0] x,
  input  wire pica_pkg::gain_t                   g,
  output logic                                   done,
  output logic signed [pica_pkg::MUL_W-1:0]      product
);
  import pica_pkg::*;

  logic signed [MUL_X_W-1:0] x_reg;
  logic signed [MUL_X_W:0]   hi;
  gain_t                     lo;
  logic [CNT_W-1:0]          cnt;
  logic signed [MUL_X_W:0]   addend;
  logic signed [MUL_X_W:0]   psum;

  // Add the operand when the current gain bit is set.
  always_comb begin
    addend = lo[0] ? (MUL_X_W+1)'(x_reg) : '0;
    psum   = hi + addend;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(GAIN_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Partial product: the high half accumulates, the low half shifts out gain bits
  // and takes in product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= g;
      x_reg <= x;
    end else if (cnt != '0) begin
      hi <= psum >>> 1;
      lo <= {psum[0], lo[GAIN_W-1:1]};
    end
  end

  // Dropping the 24 low bits of a two's complement product is a floor shift.
  assign product = {hi, lo[GAIN_W-1:GAIN_FRAC]};

endmodule

`default_nettype wire

[design/pi_controller_conditional_antiwindup_unit.sv]
// PI controller with conditional-integration anti-windup, one control tick per transaction.
// Each tick runs through the integral product states (skipped while the integrator is frozen),
// then the proportional product states and ST_OUT; the next tick is accepted only back in ST_IDLE.
// Both gain products run through one shared serial multiplier at one gain bit per cycle.
// Synchronous active-high reset clears the gains, integrator and clamp flag.
// Depends on pica_pkg, pica_if and pica_sermul.
`default_nettype none

module pi_controller_conditional_antiwindup_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [pica_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pica_pkg::CFG_DATA_W-1:0]      cfg_data,
  pica_in_if.sink                                   sample,
  pica_out_if.source                                result
);
  import pica_pkg::*;

  state_t state;
  state_t state_next;

  gain_t p_gain;
  gain_t ki_ts;
  sig_t  integrator;
  logic  last_clamped;

  logic signed [ERR_W-1:0] err;
  sig_t                    upper;
  sig_t                    lower;

  logic out_valid;
  sig_t out_drive;
  logic out_clamped;

  logic                      mul_start;
  logic signed [MUL_X_W-1:0] mul_x;
  gain_t                     mul_g;
  logic                      mul_done;
  logic signed [MUL_W-1:0]   mul_result;

  logic signed [MUL_W-1:0] acc;
  sig_t                    integ_sat;
  logic signed [SUM_W-1:0] sum;
  logic signed [MUL_W-1:0] up_ext;
  logic signed [MUL_W-1:0] low_ext;
  sig_t                    drv;
  logic                    clmp;
  logic                    out_free;
  logic                    accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= '0;
      ki_ts  <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_P_GAIN: p_gain <= cfg_data;
        REG_KI_TS:  ki_ts  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  // Shared serial multiplier.
  pica_sermul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .g       (mul_g),
    .done    (mul_done),
    .product (mul_result)
  );

  // Integrator update with saturation to the signal range.
  always_comb begin
    acc = MUL_W'(integrator) + mul_result;
    if (acc > MUL_W'(SIG_MAX)) begin
      integ_sat = SIG_MAX;
    end else if (acc < MUL_W'(SIG_MIN)) begin
      integ_sat = SIG_MIN;
    end else begin
      integ_sat = acc[SIGNAL_WIDTH-1:0];
    end
  end

  // Error plus integrator feeds the proportional product.
  assign sum = SUM_W'(err) + SUM_W'(integrator);

  // Clamp the raw output; the upper limit is tested first.
  always_comb begin
    up_ext  = MUL_W'(upper);
    low_ext = MUL_W'(lower);
    if (mul_result >= up_ext) begin
      drv  = upper;
      clmp = (mul_result != up_ext);
    end else if (mul_result <= low_ext) begin
      drv  = lower;
      clmp = (mul_result != low_ext);
    end else begin
      drv  = mul_result[SIGNAL_WIDTH-1:0];
      clmp = 1'b0;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_x      = sum;
    mul_g      = p_gain;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = last_clamped ? ST_P_START : ST_INT_START;
        end
      end
      ST_INT_START: begin
        mul_start  = 1'b1;
        mul_x      = SUM_W'(err);
        mul_g      = ki_ts;
        state_next = ST_INT_WAIT;
      end
      ST_INT_WAIT: begin
        if (mul_done) begin
          state_next = ST_P_START;
        end
      end
      ST_P_START: begin
        mul_start  = 1'b1;
        state_next = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (mul_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ticks are refused while reset is held.
  assign sample.ready = (state == ST_IDLE) && !rst;

  // Tick operands.
  always_ff @(posedge clk) begin
    if (accept) begin
      err   <= ERR_W'(sample.reference) - ERR_W'(sample.feedback);
      upper <= sample.upper_limit;
      lower <= sample.lower_limit;
    end
  end

  // Controller state: the integrator moves only when the last tick was not clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator   <= '0;
      last_clamped <= 1'b0;
    end else begin
      if (state == ST_INT_WAIT && mul_done) begin
        integrator <= integ_sat;
      end
      if (state == ST_OUT && out_free) begin
        last_clamped <= clmp;
      end
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_drive   <= drv;
      out_clamped <= clmp;
    end
  end

  assign result.valid   = out_valid;
  assign result.drive   = out_drive;
  assign result.clamped = out_clamped;

  // The multiplier only finishes while the sequencer waits on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_INT_WAIT || state == ST_P_WAIT))
    else $error("multiplier finished outside a wait state");

  // Integration only runs after an unclamped tick.
  a_integ_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INT_START) |-> !last_clamped)
    else $error("integrating while the last tick was clamped");

  // The integrator holds except at the end of the integral product.
  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_INT_WAIT && mul_done) |=> $stable(integrator))
    else $error("integrator changed outside its update");

  // An accepted tick always starts a multiplication next.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_INT_START || state == ST_P_START))
    else $error("accepted tick did not start a multiplication");

endmodule

`default_nettype wire

[tb/pica_drive_check.sv]
// Self-checking monitor for the PI controller: tracks gain writes, predicts each tick's drive.
// Compares every result transaction with the oldest prediction and counts the mismatches.
// Depends on pica_pkg and the channel interfaces in pica_if.
module pica_drive_check
  import pica_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pica_in_if                     sample,
  pica_out_if                    result,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sig_t drive;
    logic clamped;
  } drive_exp_t;

  // Shadow of the block's gains and controller state.
  gain_t      p_gain_sh;
  gain_t      ki_ts_sh;
  sig_t       integ_sh;
  logic       was_clamped_sh;
  drive_exp_t drive_expected_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Exact gain product shifted down by the gain's fraction bits, rounding toward minus infinity.
  function automatic logic signed [127:0] q24_product(input logic signed [127:0] x,
                                                      input gain_t g);
    logic signed [127:0] gw;
    gw = $signed({96'd0, g});
    return (x * gw) >>> GAIN_FRAC;
  endfunction

  // Advances the shadow state by one tick and queues the drive it should produce.
  task automatic predict_tick(input sig_t r, input sig_t f, input sig_t u, input sig_t l);
    logic signed [127:0] err;
    logic signed [127:0] acc;
    logic signed [127:0] raw;
    logic signed [127:0] wide_drive;
    drive_exp_t          e;
    err = r;
    err = err - f;
    // Integrate only when the previous tick was not clamped.
    if (!was_clamped_sh) begin
      acc = q24_product(err, ki_ts_sh);
      acc = acc + integ_sh;
      if (acc > SIG_MAX) acc = SIG_MAX;
      else if (acc < SIG_MIN) acc = SIG_MIN;
      integ_sh = sig_t'(acc[SIGNAL_WIDTH-1:0]);
    end
    raw = q24_product(err + integ_sh, p_gain_sh);
    // The upper limit is tested first, also when the limits are inverted.
    if (raw >= u) e.drive = u;
    else if (raw <= l) e.drive = l;
    else e.drive = sig_t'(raw[SIGNAL_WIDTH-1:0]);
    wide_drive = e.drive;
    e.clamped = (wide_drive != raw);
    was_clamped_sh = e.clamped;
    drive_expected_q.push_back(e);
  endtask

  always @(posedge clk) begin
    drive_exp_t e;
    if (rst) begin
      p_gain_sh      = '0;
      ki_ts_sh       = '0;
      integ_sh       = '0;
      was_clamped_sh = 1'b0;
      drive_expected_q.delete();
    end else begin
      // Gain writes; the index port is one bit wide, so every index names a register.
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_P_GAIN: p_gain_sh = cfg_data;
          REG_KI_TS:  ki_ts_sh  = cfg_data;
          default: ;
        endcase
      end
      // Result transactions are checked against the oldest prediction.
      if (result.valid && result.ready) begin
        if (drive_expected_q.size() == 0) begin
          $error("result transaction with no tick pending: drive %0d clamped %0b",
                 result.drive, result.clamped);
          mismatches++;
        end else begin
          e = drive_expected_q.pop_front();
          if (e.drive !== result.drive) begin
            $error("drive: expected %0d, actual %0d", e.drive, result.drive);
            mismatches++;
          end
          if (e.clamped !== result.clamped) begin
            $error("clamped: expected %0b, actual %0b", e.clamped, result.clamped);
            mismatches++;
          end
        end
      end
      // Each accepted tick yields exactly one prediction.
      if (sample.valid && sample.ready)
        predict_tick(sample.reference, sample.feedback, sample.upper_limit, sample.lower_limit);
    end
    outstanding <= drive_expected_q.size();
  end

endmodule

[tb/tb.sv]
// Top of the PI controller testbench: clock, reset, gain writes, tick stimulus and verdict.
// Depends on pica_pkg, pica_if, the controller unit and the pica_drive_check monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pica_pkg::*;

  localparam sig_t  Q_ONE    = 32'sh0001_0000;
  localparam gain_t GAIN_ONE = 32'h0100_0000;
  localparam gain_t GAIN_MAX = 32'hFFFF_FFFF;
  localparam int    SETTLE_CYCLES = 80;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;
  logic                   long_hold_req = 1'b0;
  logic                   tight_phase = 1'b0;

  pica_in_if  sample();
  pica_out_if result();

  pi_controller_conditional_antiwindup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .result    (result)
  );

  pica_drive_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Run limit, several times the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Result-side ready: random stretches on and off, plus one long hold-off on request.
  initial begin : result_ready_gen
    int unsigned sel;
    int          hold;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result.ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          result.ready <= 1'b1;
          hold = $urandom_range(1, 20);
        end else if (sel < 92) begin
          result.ready <= 1'b0;
          hold = $urandom_range(1, 4);
        end else begin
          result.ready <= 1'b0;
          hold = $urandom_range(20, 90);
        end
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Length of the pause after a tick: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned sel;
    if (tight_phase) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    else if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Offers one tick, waits for its transaction, then pauses at random.
  task automatic send_tick(input sig_t r, input sig_t f, input sig_t u, input sig_t l);
    int gap;
    sample.valid       <= 1'b1;
    sample.reference   <= r;
    sample.feedback    <= f;
    sample.upper_limit <= u;
    sample.lower_limit <= l;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering ticks and waits until every predicted result has been taken.
  task automatic settle();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the proportional gain, then the integral gain; only called while the block is idle.
  task automatic set_gains(input gain_t p, input gain_t ki);
    cfg_write <= 1'b1;
    cfg_index <= REG_P_GAIN;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= REG_KI_TS;
    cfg_data  <= ki;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // A signal level: mostly moderate values, sometimes full-range bits or an extreme.
  function automatic sig_t pick_level();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 15) return sig_t'($urandom());
    if (sel < 22) begin
      case ($urandom_range(0, 4))
        0:       return SIG_MAX;
        1:       return SIG_MIN;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end
    v = int'($urandom_range(0, 32'd104857600)) - 52428800;
    return sig_t'(v);
  endfunction

  // A random tick: mostly a tracking loop with ordered limits, the rest noise.
  task automatic random_tick();
    sig_t        r;
    sig_t        f;
    sig_t        u;
    sig_t        l;
    int unsigned sel;
    r = pick_level();
    if ($urandom_range(0, 3) != 0)
      f = r - sig_t'(int'($urandom_range(0, 32'd6553600)) - 3276800);
    else
      f = pick_level();
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      u = sig_t'($urandom_range(0, 32'd65536000));
      l = -sig_t'($urandom_range(0, 32'd65536000));
    end else if (sel < 90) begin
      u = -sig_t'($urandom_range(0, 32'd65536000));
      l = sig_t'($urandom_range(1, 32'd65536000));
    end else begin
      u = pick_level();
      l = pick_level();
    end
    send_tick(r, f, u, l);
  endtask

  initial begin : stimulus
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= REG_P_GAIN;
    cfg_data           <= '0;
    sample.valid       <= 1'b0;
    sample.reference   <= '0;
    sample.feedback    <= '0;
    sample.upper_limit <= '0;
    sample.lower_limit <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Gains at their reset value of zero: raw output is zero.
    send_tick('0, '0, '0, '0);
    send_tick(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
    settle();

    // Huge integral gain with no proportional path: integrator saturates both ways.
    set_gains('0, GAIN_MAX);
    send_tick(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
    send_tick(SIG_MIN, SIG_MAX, SIG_MAX, SIG_MIN);
    settle();

    // Unity integral gain brings the saturated integrator back to exactly zero.
    set_gains('0, GAIN_ONE);
    send_tick('0, SIG_MIN, SIG_MAX, SIG_MIN);
    settle();

    // Unity proportional gain, frozen integrator: raw output equals the error.
    set_gains(GAIN_ONE, '0);
    send_tick(100, 0, 100, -100);
    send_tick(-100, 0, 100, -100);
    send_tick(200, 0, 100, -100);
    send_tick(-200, 0, 100, -100);
    send_tick(50, 0, 100, -100);
    send_tick(0, 0, -100, 100);
    send_tick(150, 0, -100, 100);
    send_tick(-150, 0, -100, 100);
    send_tick(5, 0, 5, 5);
    send_tick(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
    send_tick(SIG_MIN, SIG_MAX, SIG_MAX, SIG_MIN);
    settle();

    // Quarter integral gain: floor rounding, clamp-then-freeze, then release.
    set_gains(GAIN_ONE, 32'h0040_0000);
    send_tick(Q_ONE, 0, SIG_MAX, SIG_MIN);
    send_tick(-1, 0, SIG_MAX, SIG_MIN);
    send_tick(Q_ONE * 16, 0, Q_ONE, SIG_MIN);
    send_tick(Q_ONE * 16, 0, Q_ONE, SIG_MIN);
    send_tick('0, '0, SIG_MAX, SIG_MIN);
    send_tick(Q_ONE, 0, SIG_MAX, SIG_MIN);
    settle();

    // Random phases, each with its own gain setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_gains(32'h0080_0000, 32'h0008_0000);
        1:       set_gains(GAIN_MAX, GAIN_MAX);
        2:       set_gains('0, GAIN_MAX);
        3:       set_gains(GAIN_MAX, '0);
        4:       set_gains($urandom(), $urandom());
        default: set_gains($urandom_range(32'h0001_0000, 32'h0400_0000),
                           $urandom_range(32'h0000_1000, 32'h0100_0000));
      endcase
      tight_phase = ($urandom_range(0, 3) == 0);
      // The first phase also holds the result side off long enough to back up the input.
      if (ph == 0) long_hold_req = 1'b1;
      repeat (75) random_tick();
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
